FILE: rtl/core/frct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frct_pkg;

  typedef enum logic [1:0] {
    KIND_FRAG    = 2'd0,
    KIND_ADD_REF = 2'd1,
    KIND_REL_REF = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_RX   = 2'd1,
    SLOT_REF  = 2'd2
  } slot_st_t;

  typedef enum logic [3:0] {
    STAT_OK       = 4'd0,
    STAT_COMPLETE = 4'd1,
    STAT_ORDER    = 4'd2,
    STAT_DUP      = 4'd3,
    STAT_OVERRUN  = 4'd4,
    STAT_FINAL    = 4'd5,
    STAT_NOCTX    = 4'd6,
    STAT_BADLEN   = 4'd7,
    STAT_UNUSED   = 4'd8
  } status_t;

  localparam logic [31:0] RX_TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] total;
    logic [7:0]  frag_count;
    logic [7:0]  next_frag;
    logic [15:0] bytes;
    logic [31:0] last_rx;
    logic [7:0]  refs;
  } slot_rec_t;

  typedef struct packed {
    logic expired;
    logic match;
    logic free;
  } scan_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/frct_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module frct_slot_mem
  import frct_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic      clk,
  input  wire logic      wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_rec_t wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output slot_rec_t      rd_data
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/frct_scan.sv
`timescale 1ns / 1ps
`default_nettype none
module frct_scan
  import frct_pkg::*;
(
  input  wire slot_rec_t    rec,
  input  wire slot_st_t     st,
  input  wire logic [31:0]  now_ms,
  input  wire logic [31:0]  timeout,
  input  wire logic [15:0]  seq_id,
  input  wire logic [15:0]  total_size,
  input  wire logic [7:0]   frag_count,
  output scan_res_t         res
);

  logic [31:0] age;
  logic        expired;
  logic        live;

  // age wraps modulo 2^32
  assign age     = now_ms - rec.last_rx;
  assign expired = (st == SLOT_RX) && (age >= timeout);
  assign live    = (st == SLOT_RX) && !expired;

  assign res.expired = expired;
  assign res.match   = live && (rec.seq == seq_id) && (rec.frag_count == frag_count)
                       && (rec.total == total_size);
  assign res.free    = (st == SLOT_FREE) || expired;

endmodule
`default_nettype wire

FILE: rtl/core/fragment_reassembly_context_table.sv
// Fragment reassembly context table.
// Input channel (in_valid/in_stall) carries one item: a fragment arrival
// (kind 0), a reference add (kind 1) or a reference release (kind 2). Kind 3
// is taken and dropped with no result. Every other item gives exactly one
// result on the output channel (out_valid/out_stall).
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the receive
// timeout in ms; cfg_ready is always high. Write it only while idle.
// One item is worked on at a time; in_stall is high until the block is back
// in idle. A fragment scans the slot record memory one slot per cycle through
// a single age/match compare unit, then, if a slot is found or claimed, reads,
// updates and writes back that slot. A reference item skips the scan and goes
// straight to the slot read. A dropped kind 3 item leaves the block in idle.
// The result sits in an output register; while out_stall is high it holds,
// and the next item is processed up to its own result, then waits.
// Synchronous reset frees all slots, empties the output register and sets
// the timeout to 1000. Slot records are not cleared; a free slot's record
// is never used.
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembly_context_table
  import frct_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] seq_id,
  input  wire logic [15:0] total_size,
  input  wire logic [7:0]  frag_index,
  input  wire logic [7:0]  frag_count,
  input  wire logic [15:0] frag_length,
  input  wire logic [2:0]  slot_sel,
  input  wire logic [31:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic             slot_valid,
  output logic [2:0]       slot_out,
  output logic [15:0]      received_bytes,
  output logic [7:0]       expected_frag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int XW = (SW > 3) ? SW : 3;
  localparam logic [SW:0] SCAN_END = (SW + 1)'(NUM_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_EXEC = 5'b01000,
    S_OUT  = 5'b10000
  } fsm_t;

  fsm_t        state;
  logic [31:0] rx_timeout;
  slot_st_t    slot_state [NUM_SLOTS];

  // captured item
  kind_t       q_kind;
  logic [15:0] q_seq;
  logic [15:0] q_total;
  logic [7:0]  q_fidx;
  logic [7:0]  q_fcnt;
  logic [15:0] q_len;
  logic [31:0] q_now;
  logic        q_in_range;

  logic [SW:0]   scan_idx;
  logic          ev_vld;
  logic [SW-1:0] ev_idx;
  logic          have_match;
  logic [SW-1:0] match_idx;
  logic          have_free;
  logic [SW-1:0] free_idx;
  logic          claim;
  logic [SW-1:0] s_idx;

  // pending result
  status_t     res_status;
  logic        res_vld;
  logic [2:0]  res_slot;
  logic [15:0] res_bytes;
  logic [7:0]  res_next;

  status_t     out_status;

  logic          accept;
  logic          in_range;
  logic [XW-1:0] sel_x;
  logic [XW-1:0] s_x;

  logic [SW-1:0] rd_addr;
  slot_rec_t     rd_q;
  scan_res_t     scan;

  slot_rec_t   fresh;
  slot_rec_t   cur;
  slot_rec_t   nrec;
  slot_st_t    nst;
  slot_st_t    cur_st;
  logic        ex_wr;
  status_t     ex_status;
  logic        ex_vld;
  logic [16:0] sum;
  logic [7:0]  next_inc;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_range = ({29'd0, slot_sel} < 32'(NUM_SLOTS));
  assign sel_x    = XW'(slot_sel);
  assign s_x      = XW'(s_idx);

  assign rd_addr = (state == S_SCAN) ? scan_idx[SW-1:0] : s_idx;

  frct_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (state == S_EXEC && ex_wr),
    .wr_addr (s_idx),
    .wr_data (nrec),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  frct_scan u_scan (
    .rec        (rd_q),
    .st         (slot_state[ev_idx]),
    .now_ms     (q_now),
    .timeout    (rx_timeout),
    .seq_id     (q_seq),
    .total_size (q_total),
    .frag_count (q_fcnt),
    .res        (scan)
  );

  always_comb begin
    fresh.seq        = q_seq;
    fresh.total      = q_total;
    fresh.frag_count = q_fcnt;
    fresh.next_frag  = 8'd0;
    fresh.bytes      = 16'd0;
    fresh.last_rx    = q_now;
    fresh.refs       = 8'd1;
    cur      = claim ? fresh : rd_q;
    cur_st   = slot_state[s_idx];
    sum      = {1'b0, cur.bytes} + {1'b0, q_len};
    next_inc = cur.next_frag + 8'd1;
    nrec      = cur;
    nst       = cur_st;
    ex_wr     = 1'b0;
    ex_vld    = 1'b1;
    ex_status = STAT_OK;
    if (q_kind == KIND_FRAG) begin
      nst   = SLOT_RX;
      ex_wr = claim;
      if (q_len == 16'd0) begin
        ex_status = STAT_BADLEN;
      end else if (q_fidx > cur.next_frag) begin
        ex_status = STAT_ORDER;
      end else if (q_fidx < cur.next_frag) begin
        ex_status = STAT_DUP;
      end else if (sum > {1'b0, cur.total}) begin
        ex_status = STAT_OVERRUN;
      end else begin
        ex_wr          = 1'b1;
        nrec.bytes     = sum[15:0];
        nrec.last_rx   = q_now;
        nrec.next_frag = next_inc;
        if (next_inc == cur.frag_count) begin
          if (sum[15:0] != cur.total) begin
            ex_status = STAT_FINAL;
          end else begin
            nst       = SLOT_REF;
            ex_status = STAT_COMPLETE;
          end
        end
      end
    end else if (!q_in_range || cur_st == SLOT_FREE) begin
      ex_status = STAT_UNUSED;
      ex_vld    = 1'b0;
    end else if (q_kind == KIND_ADD_REF) begin
      ex_wr     = 1'b1;
      nrec.refs = cur.refs + 8'd1;
    end else begin
      ex_wr = 1'b1;
      if (cur.refs == 8'd1) begin
        nrec.refs = 8'd0;
        nst       = SLOT_FREE;
      end else begin
        nrec.refs = cur.refs - 8'd1;
      end
    end
  end

  // sequencer and slot states
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ev_vld     <= 1'b0;
      rx_timeout <= RX_TIMEOUT_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_state[i] <= SLOT_FREE;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        rx_timeout <= cfg_data;
      end
      ev_vld <= (state == S_SCAN) && (scan_idx != SCAN_END);
      if (ev_vld && scan.expired) begin
        slot_state[ev_idx] <= SLOT_FREE;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind_t'(kind))
              KIND_FRAG:    state <= S_SCAN;
              KIND_ADD_REF: state <= S_READ;
              KIND_REL_REF: state <= S_READ;
              default:      state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx == SCAN_END && !ev_vld) begin
            if (have_match || (q_fidx == 8'd0 && have_free)) begin
              state <= S_READ;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state <= S_OUT;
          if (ex_wr) begin
            slot_state[s_idx] <= nst;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture, scan bookkeeping and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      q_kind     <= kind_t'(kind);
      q_seq      <= seq_id;
      q_total    <= total_size;
      q_fidx     <= frag_index;
      q_fcnt     <= frag_count;
      q_len      <= frag_length;
      q_now      <= now_ms;
      q_in_range <= in_range;
      s_idx      <= sel_x[SW-1:0];
      claim      <= 1'b0;
      scan_idx   <= '0;
      have_match <= 1'b0;
      have_free  <= 1'b0;
    end
    if (state == S_SCAN) begin
      if (scan_idx != SCAN_END) begin
        scan_idx <= scan_idx + {{SW{1'b0}}, 1'b1};
      end
      ev_idx <= scan_idx[SW-1:0];
      if (scan_idx == SCAN_END && !ev_vld) begin
        if (have_match) begin
          s_idx <= match_idx;
        end else if (q_fidx == 8'd0 && have_free) begin
          s_idx <= free_idx;
          claim <= 1'b1;
        end else begin
          res_status <= STAT_NOCTX;
          res_vld    <= 1'b0;
          res_slot   <= 3'd0;
          res_bytes  <= 16'd0;
          res_next   <= 8'd0;
        end
      end
    end
    if (ev_vld) begin
      // keep the lowest matching and the lowest free slot
      if (scan.match && !have_match) begin
        have_match <= 1'b1;
        match_idx  <= ev_idx;
      end
      if (scan.free && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= ev_idx;
      end
    end
    if (state == S_EXEC) begin
      res_status <= ex_status;
      res_vld    <= ex_vld;
      res_slot   <= ex_vld ? s_x[2:0] : 3'd0;
      res_bytes  <= ex_vld ? nrec.bytes : 16'd0;
      res_next   <= ex_vld ? nrec.next_frag : 8'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_status     <= res_status;
      slot_valid     <= res_vld;
      slot_out       <= res_slot;
      received_bytes <= res_bytes;
      expected_frag  <= res_next;
    end
  end

  assign status = out_status;

endmodule
`default_nettype wire

FILE: rtl/core/frct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module frct_checker
  import frct_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  status,
  input wire logic        slot_valid,
  input wire logic [2:0]  slot_out,
  input wire logic [15:0] received_bytes,
  input wire logic [7:0]  expected_frag
);

  // a result waiting on the receiver holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_out)
      && $stable(received_bytes))
    else $error("stalled result changed");

  // a real item keeps the block busy in the cycle after it is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind != KIND_NONE |=> in_stall)
    else $error("block took a new item without processing");

  // a result without a slot carries zero slot fields
  a_noslot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slot_valid |-> slot_out == 3'd0 && received_bytes == 16'd0
      && expected_frag == 8'd0)
    else $error("slot fields set without a slot");

  // slot-less results are exactly no_context and slot_unused
  a_noslot_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!slot_valid) == (status == STAT_NOCTX || status == STAT_UNUSED))
    else $error("slot_valid does not agree with status");

endmodule

bind fragment_reassembly_context_table frct_checker u_frct_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .kind           (kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .slot_valid     (slot_valid),
  .slot_out       (slot_out),
  .received_bytes (received_bytes),
  .expected_frag  (expected_frag)
);
`default_nettype wire
